// ===== rtl/core/tcpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_CLASS_COUNT = 3;
    localparam int DEF_ID_WIDTH    = 32;

    // Fixed field widths of the stream payloads.
    localparam int CLASS_IN_W  = 2;
    localparam int ITEM_ID_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int SERVED_ID_W = 32;
    localparam int SERVED_CL_W = 2;

    // Depth of the operation queue between front and back.
    localparam int OP_FIFO_DEPTH = 4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Operation kinds carried from the front to the back.
    localparam logic [1:0] OP_STORE  = 2'd0;  // write an id into the store
    localparam logic [1:0] OP_FETCH  = 2'd1;  // read an id out of the store
    localparam logic [1:0] OP_REPORT = 2'd2;  // status only, no store access

    // Command codes on the input stream.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic [1:0]             kind;
        logic [STATUS_W-1:0]    status;
        logic [SERVED_CL_W-1:0] served_class;
    } op_ctl_t;

    localparam int OP_CTL_W = $bits(op_ctl_t);

endpackage
`default_nettype wire

// ===== rtl/core/tcpq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_front
// Accepts commands, keeps the per-class ring pointers and counts, and turns
// each command into one store operation for the back end.
// ----------------------------------------------------------------------------
module tcpq_front
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CLASS_COUNT = DEF_CLASS_COUNT,
    parameter int ID_WIDTH    = DEF_ID_WIDTH,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int CLS_W      = $clog2(CLASS_COUNT),
    localparam int ADDR_W     = CLS_W + PTR_W
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  command,
    input  wire logic [CLASS_IN_W-1:0] class_in,
    input  wire logic [ITEM_ID_W-1:0]  item_id,
    output logic                       op_valid,
    input  wire logic                  op_ready,
    output op_ctl_t                    op_ctl,
    output logic [ADDR_W-1:0]          op_addr,
    output logic [ID_WIDTH-1:0]        op_id
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [OCC_W-1:0] occ_reg  [CLASS_COUNT];
    logic [OCC_W-1:0] occ_next [CLASS_COUNT];
    logic [PTR_W-1:0] head_reg  [CLASS_COUNT];
    logic [PTR_W-1:0] head_next [CLASS_COUNT];
    logic [PTR_W-1:0] tail_reg  [CLASS_COUNT];
    logic [PTR_W-1:0] tail_next [CLASS_COUNT];

    logic             accept;
    logic             class_ok;
    logic [CLS_W-1:0] enq_cls;
    logic [CLS_W-1:0] pick_cls;
    logic             pick_found;

    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign accept   = in_valid && op_ready;
    assign enq_cls  = CLS_W'(class_in);
    assign class_ok = int'(class_in) < CLASS_COUNT;

    // Strict priority: the lowest-numbered class that holds an entry wins.
    always_comb
    begin
        pick_cls   = '0;
        pick_found = 1'b0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if (occ_reg[c] != '0)
            begin
                pick_cls   = CLS_W'(c);
                pick_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        occ_next  = occ_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        op_ctl    = '{kind: OP_REPORT, status: ST_OK, served_class: '0};
        op_addr   = '0;
        op_id     = ID_WIDTH'(item_id);
        priority if (command == CMD_ENQUEUE && !class_ok)
        begin
            op_ctl.status = ST_INVALID;
        end
        else if (command == CMD_ENQUEUE && occ_reg[enq_cls] == OCC_FULL)
        begin
            op_ctl.status = ST_FULL;
        end
        else if (command == CMD_ENQUEUE)
        begin
            op_ctl.kind = OP_STORE;
            op_addr     = {enq_cls, tail_reg[enq_cls]};
            if (accept)
            begin
                occ_next[enq_cls]  = occ_reg[enq_cls] + 1'b1;
                tail_next[enq_cls] = (tail_reg[enq_cls] == PTR_LAST) ? '0
                                   : tail_reg[enq_cls] + 1'b1;
            end
        end
        else if (pick_found)
        begin
            op_ctl.kind         = OP_FETCH;
            op_ctl.served_class = SERVED_CL_W'(pick_cls);
            op_addr             = {pick_cls, head_reg[pick_cls]};
            if (accept)
            begin
                occ_next[pick_cls]  = occ_reg[pick_cls] - 1'b1;
                head_next[pick_cls] = (head_reg[pick_cls] == PTR_LAST) ? '0
                                    : head_reg[pick_cls] + 1'b1;
            end
        end
        else
        begin
            op_ctl.status = ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                occ_reg[c]  <= '0;
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
            end
        end
        else
        begin
            occ_reg  <= occ_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tcpq_op_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_op_fifo
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module tcpq_op_fifo
    import tcpq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = OP_FIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tcpq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_back
// Executes store operations on the entry memory and registers the results.
// ----------------------------------------------------------------------------
module tcpq_back
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CLASS_COUNT = DEF_CLASS_COUNT,
    parameter int ID_WIDTH    = DEF_ID_WIDTH,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int CLS_W      = $clog2(CLASS_COUNT),
    localparam int ADDR_W     = CLS_W + PTR_W
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    op_valid,
    output logic                         op_ready,
    input  wire op_ctl_t                 op_ctl,
    input  wire logic [ADDR_W-1:0]       op_addr,
    input  wire logic [ID_WIDTH-1:0]     op_id,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STATUS_W-1:0]          status,
    output logic [SERVED_ID_W-1:0]       served_id,
    output logic [SERVED_CL_W-1:0]       served_class,
    output logic                         served_valid
);

    localparam int MEM_DEPTH = CLASS_COUNT * (1 << PTR_W);

    logic [ID_WIDTH-1:0]    mem [MEM_DEPTH];
    logic [ID_WIDTH-1:0]    rd_data_reg;

    // Stage one: memory access issued, control waiting for the read data.
    logic                   s1_valid_reg;
    op_ctl_t                s1_ctl_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [SERVED_ID_W-1:0] served_id_reg;
    logic [SERVED_CL_W-1:0] served_class_reg;
    logic                   served_valid_reg;

    logic                   out_free;
    logic                   s1_move;
    logic                   do_pop;
    logic                   s1_fetch;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign op_ready = !s1_valid_reg || out_free;
    assign do_pop   = op_valid && op_ready;
    assign s1_fetch = s1_ctl_reg.kind == OP_FETCH;

    always_ff @(posedge clk)
    begin
        if (do_pop && op_ctl.kind == OP_STORE)
        begin
            mem[op_addr] <= op_id;
        end
        if (do_pop && op_ctl.kind == OP_FETCH)
        begin
            rd_data_reg <= mem[op_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            s1_ctl_reg <= op_ctl;
        end
        if (s1_move)
        begin
            status_reg       <= s1_ctl_reg.status;
            served_class_reg <= s1_ctl_reg.served_class;
            served_valid_reg <= s1_fetch;
            served_id_reg    <= s1_fetch ? SERVED_ID_W'(rd_data_reg) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_id    = served_id_reg;
    assign served_class = served_class_reg;
    assign served_valid = served_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/three_class_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Strict priority queue with one bounded FIFO per class and stream ports.
// ----------------------------------------------------------------------------
// Each input item is one command and yields exactly one result item. An
// enqueue appends item_id to the FIFO of class_in; a dequeue removes the
// oldest id from the lowest-numbered class that holds one (class 0 is the
// most urgent) and returns it with its class. Rejected commands return a
// status only: invalid class, queue full or all queues empty. The block
// accepts one item per clock cycle while the operation queue has room,
// limited by the single entry memory, which takes one write or one read
// each cycle. An item passes the operation queue, stage one and the result
// register on its way out. A short operation queue decouples the front,
// which does all pointer and count bookkeeping at acceptance, from the
// back, which performs the memory access, so either stream may stall
// without starving the other. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module three_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,  // entries per class, 2 to 4096
    parameter int CLASS_COUNT = DEF_CLASS_COUNT,  // number of classes, 2 to 4
    parameter int ID_WIDTH    = DEF_ID_WIDTH      // stored id bits, 8 to 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] class_in, [33:2] item_id, [39:34] zero
    input  wire logic [39:0] s_axis_tdata,
    // [0] command
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [33:2] served_id, [35:34] served_class,
    // [36] served_valid, [39:37] zero
    output logic [39:0]      m_axis_tdata
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CLS_W  = $clog2(CLASS_COUNT);
    localparam int ADDR_W = CLS_W + PTR_W;
    localparam int OP_W   = OP_CTL_W + ADDR_W + ID_WIDTH;

    // Front side of the operation queue.
    logic                   f_valid;
    logic                   f_ready;
    op_ctl_t                f_ctl;
    logic [ADDR_W-1:0]      f_addr;
    logic [ID_WIDTH-1:0]    f_id;

    // Back side of the operation queue.
    logic                   b_valid;
    logic                   b_ready;
    logic [OP_W-1:0]        b_data;
    op_ctl_t                b_ctl;
    logic [ADDR_W-1:0]      b_addr;
    logic [ID_WIDTH-1:0]    b_id;

    logic [STATUS_W-1:0]    status;
    logic [SERVED_ID_W-1:0] served_id;
    logic [SERVED_CL_W-1:0] served_class;
    logic                   served_valid;

    // Commands are classified and the ring pointers move at acceptance, so
    // the back end only ever sees the exact memory slot to touch.
    tcpq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CLASS_COUNT (CLASS_COUNT),
        .ID_WIDTH    (ID_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .command  (s_axis_tuser),
        .class_in (s_axis_tdata[1:0]),
        .item_id  (s_axis_tdata[33:2]),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op_ctl   (f_ctl),
        .op_addr  (f_addr),
        .op_id    (f_id)
    );

    // Operations stay in order, so a fetch never passes the store that
    // filled its slot.
    tcpq_op_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_FIFO_DEPTH)
    ) u_op_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_addr, f_id}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_ctl, b_addr, b_id} = b_data;

    tcpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CLASS_COUNT (CLASS_COUNT),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (b_valid),
        .op_ready     (b_ready),
        .op_ctl       (b_ctl),
        .op_addr      (b_addr),
        .op_id        (b_id),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .status       (status),
        .served_id    (served_id),
        .served_class (served_class),
        .served_valid (served_valid)
    );

    assign m_axis_tdata = {3'b000, served_valid, served_class, served_id, status};

endmodule
`default_nettype wire

// ===== tb/tb_three_class_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_class_priority_queue
// Self-checking stream testbench for the three-class strict priority queue.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the three class rings and, for
// every command item the block accepts, works out the response the block
// must give. Responses are compared field by field in arrival order. The
// stimulus starts with a short hand-written sequence and then runs random
// sequences: mixed traffic, bursts that fill one class to its limit, drains
// that run all queues dry, and unshaped noise. The sender pauses in random
// gaps between bursts, the receiver stalls on changing patterns, and twice
// the receiver holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_three_class_priority_queue;
    import tcpq_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_ITEMS     = 1500;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PRESSURE_ITEMS   = 72;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RUN_LIMIT_NS     = 5_000_000;

    localparam int SLOT_W = $clog2(DEF_QUEUE_DEPTH);
    localparam int FILL_W = $clog2(DEF_QUEUE_DEPTH + 1);

    // Priority classes as the command stream names them.
    localparam logic [CLASS_IN_W-1:0] CLASS_SERIOUS = 2'd0;
    localparam logic [CLASS_IN_W-1:0] CLASS_MEDIUM  = 2'd1;
    localparam logic [CLASS_IN_W-1:0] CLASS_GENERAL = 2'd2;
    localparam logic [CLASS_IN_W-1:0] CLASS_INVALID = 2'd3;

    // Receiver stall patterns.
    typedef enum int
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    // One response item; the first member lands in the highest bits, so the
    // struct lines up with m_axis_tdata[36:0].
    typedef struct packed {
        logic                   served_valid;
        logic [SERVED_CL_W-1:0] served_class;
        logic [SERVED_ID_W-1:0] served_id;
        logic [STATUS_W-1:0]    status;
    } response_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the class rings and holds the responses still owed.
    // ------------------------------------------------------------------------
    class serve_order_book;
        logic [ITEM_ID_W-1:0] id_store [DEF_CLASS_COUNT][DEF_QUEUE_DEPTH];
        logic [SLOT_W-1:0]    head_slot [DEF_CLASS_COUNT];
        logic [SLOT_W-1:0]    tail_slot [DEF_CLASS_COUNT];
        logic [FILL_W-1:0]    fill_level [DEF_CLASS_COUNT];
        response_t            owed_responses [$];
        int                   errors;
        int                   checked;
        int                   status_count [4];

        function new();
            for (int c = 0; c < DEF_CLASS_COUNT; c++)
            begin
                head_slot[c]  = '0;
                tail_slot[c]  = '0;
                fill_level[c] = '0;
            end
            errors  = 0;
            checked = 0;
            for (int s = 0; s < 4; s++)
                status_count[s] = 0;
        endfunction

        function logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
            return (s == DEF_QUEUE_DEPTH - 1) ? '0 : s + 1'b1;
        endfunction

        // Applies one accepted command to the mirrored rings and returns the
        // response it must produce.
        function response_t serve_or_store(logic cmd, logic [CLASS_IN_W-1:0] cls,
                                           logic [ITEM_ID_W-1:0] id);
            response_t r;
            bit        found;
            r     = '0;
            found = 1'b0;
            if (cmd == CMD_ENQUEUE)
            begin
                if (cls >= DEF_CLASS_COUNT)
                    r.status = ST_INVALID;
                else if (fill_level[cls] >= DEF_QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    id_store[cls][tail_slot[cls]] = id;
                    tail_slot[cls]  = next_slot(tail_slot[cls]);
                    fill_level[cls] = fill_level[cls] + 1'b1;
                    r.status = ST_OK;
                end
            end
            else
            begin
                r.status = ST_EMPTY;
                for (int c = 0; c < DEF_CLASS_COUNT; c++)
                begin
                    if (!found && fill_level[c] != 0)
                    begin
                        found          = 1'b1;
                        r.status       = ST_OK;
                        r.served_id    = id_store[c][head_slot[c]];
                        r.served_class = c[SERVED_CL_W-1:0];
                        r.served_valid = 1'b1;
                        head_slot[c]   = next_slot(head_slot[c]);
                        fill_level[c]  = fill_level[c] - 1'b1;
                    end
                end
            end
            return r;
        endfunction

        function void note_command(logic cmd, logic [CLASS_IN_W-1:0] cls,
                                   logic [ITEM_ID_W-1:0] id);
            owed_responses.push_back(serve_or_store(cmd, cls, id));
        endfunction

        function int owed_count();
            return owed_responses.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        task check_result(logic [39:0] beat);
            response_t got;
            response_t want;
            got = beat[36:0];
            if (owed_responses.size() == 0)
            begin
                report_mismatch("result with no command waiting", beat[31:0], 32'd0);
                return;
            end
            want = owed_responses.pop_front();
            checked++;
            status_count[want.status]++;
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.served_id !== want.served_id)
                report_mismatch("served_id", got.served_id, want.served_id);
            if (got.served_class !== want.served_class)
                report_mismatch("served_class", 32'(got.served_class),
                                32'(want.served_class));
            if (got.served_valid !== want.served_valid)
                report_mismatch("served_valid", 32'(got.served_valid),
                                32'(want.served_valid));
        endtask

        task check_leftovers();
            if (owed_responses.size() != 0)
                report_mismatch("commands left without a result",
                                32'(owed_responses.size()), 32'd0);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [1:0] class_in, [33:2] item_id, [39:34] zero
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [1:0] status, [33:2] served_id,
                                 // [35:34] served_class, [36] served_valid

    three_class_priority_queue dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    serve_order_book book;

    // Sender pacing and bookkeeping shared by the stimulus tasks.
    int items_sent     = 0;
    int burst_left     = 0;
    bit pacing_off     = 1'b0;
    bit hold_requested = 1'b0;
    int hold_cycles    = 0;
    int holds_done     = 0;

    // 20 ns clock.
    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Hard limit on the run, far above the slowest legal run.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("[%0t] timeout with %0d responses still owed", $time, book.owed_count());
        $display("simulation failed");
        $finish;
    end

    // Every response item that the receiver takes is checked at the edge
    // that moves it. Values read here are the ones settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // Receiver: tready changes at the falling edge. The stall pattern switches
    // now and then; a long hold-off is granted when the stimulus asks for it
    // and is counted down here, one cycle at a time.
    // ------------------------------------------------------------------------
    initial
    begin
        ready_mode_t mode;
        int          mode_left;
        int          period;
        int          phase;
        int          hold_left;
        mode          = READY_ALWAYS;
        mode_left     = 0;
        period        = 2;
        phase         = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                hold_left      = LONG_HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_cycles++;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    period    = $urandom_range(2, 5);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase = (phase + 1) % period;
                case (mode)
                    READY_ALWAYS:   m_axis_tready <= 1'b1;
                    READY_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) < 60);
                    READY_PERIODIC: m_axis_tready <= (phase == 0);
                    default:        m_axis_tready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Inputs change at the falling edge; acceptance is seen at
    // the rising edge, where the scoreboard takes note of the command.
    // ------------------------------------------------------------------------
    task send_command(input logic cmd, input logic [CLASS_IN_W-1:0] cls,
                      input logic [ITEM_ID_W-1:0] id);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, id, cls};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        book.note_command(cmd, cls, id);
        items_sent++;
    endtask

    // Sends in bursts of random length, with idle gaps of random length in
    // between. Now and then a gap of zero joins two bursts into one stretch.
    task send_paced(input logic cmd, input logic [CLASS_IN_W-1:0] cls,
                    input logic [ITEM_ID_W-1:0] id);
        int          gap;
        logic [31:0] junk;
        if (!pacing_off && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                junk = $urandom;
                s_axis_tvalid <= 1'b0;
                s_axis_tuser  <= junk[0];
                s_axis_tdata  <= {6'b0, junk, junk[31:30]};
            end
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        send_command(cmd, cls, id);
    endtask

    task enqueue(input logic [CLASS_IN_W-1:0] cls, input logic [ITEM_ID_W-1:0] id);
        send_paced(CMD_ENQUEUE, cls, id);
    endtask

    // A dequeue carries random class and id fields, which the block ignores.
    task dequeue();
        logic [CLASS_IN_W-1:0] cls;
        cls = CLASS_IN_W'($urandom_range(0, 3));
        send_paced(CMD_DEQUEUE, cls, $urandom);
    endtask

    // Mixed traffic: half enqueues, mostly to legal classes, half dequeues.
    task run_mixed(input int count);
        logic [CLASS_IN_W-1:0] cls;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 50)
            begin
                cls = ($urandom_range(0, 9) == 0) ? CLASS_INVALID
                                                  : CLASS_IN_W'($urandom_range(0, 2));
                enqueue(cls, $urandom);
            end
            else
                dequeue();
        end
    endtask

    // Piles enqueues into one class, usually until it reports full.
    task run_fill(input logic [CLASS_IN_W-1:0] cls, input int count);
        for (int i = 0; i < count; i++)
            enqueue(cls, $urandom);
    endtask

    task run_drain(input int count);
        for (int i = 0; i < count; i++)
            dequeue();
    endtask

    // Commands with every field random, invalid classes included.
    task run_noise(input int count);
        logic                  cmd;
        logic [CLASS_IN_W-1:0] cls;
        for (int i = 0; i < count; i++)
        begin
            cmd = 1'($urandom_range(0, 1));
            cls = CLASS_IN_W'($urandom_range(0, 3));
            send_paced(cmd, cls, $urandom);
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers a
    // back-to-back fill, so the block backs up and drops s_axis_tready.
    task run_pressure();
        logic [CLASS_IN_W-1:0] cls;
        cls            = CLASS_IN_W'($urandom_range(0, 2));
        hold_requested = 1'b1;
        pacing_off     = 1'b1;
        run_fill(cls, PRESSURE_ITEMS);
        pacing_off     = 1'b0;
        burst_left     = 0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int directed_items;
        int pick;
        book          = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = CMD_ENQUEUE;
        s_axis_tdata  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, sent back to back. It opens with a dequeue on an
        // empty block and an enqueue with the invalid class.
        pacing_off = 1'b1;
        send_command(CMD_DEQUEUE, CLASS_SERIOUS, 32'h0000_0000);
        send_command(CMD_ENQUEUE, CLASS_INVALID, 32'hFFFF_FFFF);
        // Entries land in reverse priority order; the dequeues must still
        // come out serious first, then medium, then general in FIFO order.
        send_command(CMD_ENQUEUE, CLASS_GENERAL, 32'h0000_0000);
        send_command(CMD_ENQUEUE, CLASS_GENERAL, 32'h5A5A_5A5A);
        send_command(CMD_ENQUEUE, CLASS_MEDIUM,  32'hFFFF_FFFF);
        send_command(CMD_ENQUEUE, CLASS_SERIOUS, 32'hA5A5_A5A5);
        send_command(CMD_ENQUEUE, CLASS_SERIOUS, 32'h0000_0001);
        send_command(CMD_DEQUEUE, CLASS_INVALID, 32'hFFFF_FFFF);
        send_command(CMD_ENQUEUE, CLASS_MEDIUM,  32'h8000_0000);
        send_command(CMD_DEQUEUE, CLASS_GENERAL, 32'h1234_5678);
        send_command(CMD_DEQUEUE, CLASS_SERIOUS, 32'h0000_0000);
        send_command(CMD_DEQUEUE, CLASS_MEDIUM,  32'h0000_0000);
        send_command(CMD_DEQUEUE, CLASS_SERIOUS, 32'h0000_0000);
        send_command(CMD_DEQUEUE, CLASS_SERIOUS, 32'h0000_0000);
        send_command(CMD_DEQUEUE, CLASS_SERIOUS, 32'h0000_0000);
        // All queues are empty again: one more dequeue must report empty.
        send_command(CMD_DEQUEUE, CLASS_INVALID, 32'hDEAD_BEEF);
        send_command(CMD_ENQUEUE, CLASS_INVALID, 32'h0000_0000);
        pacing_off     = 1'b0;
        directed_items = items_sent;

        // Random part. Two long receiver hold-offs fall early on; the rest is
        // a mix of sequence shapes, with fills and drains pushing every class
        // around its ring many times and into the full and empty cases.
        while (items_sent - directed_items < RANDOM_ITEMS)
        begin
            if (holds_done < 2 && items_sent - directed_items >= 300 * (holds_done + 1))
            begin
                run_pressure();
                wait (hold_requested == 1'b0);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    run_mixed($urandom_range(10, 60));
                else if (pick < 60)
                    run_fill(CLASS_IN_W'($urandom_range(0, 2)), $urandom_range(20, 70));
                else if (pick < 80)
                    run_drain($urandom_range(20, 120));
                else
                    run_noise($urandom_range(5, 20));
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Wait for every owed response, then a further settle period so that a
        // stray extra response would still be caught.
        while (book.owed_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        book.check_leftovers();

        $display("Checked %0d responses to %0d commands: %0d ok, %0d invalid class, %0d empty, %0d full.",
                 book.checked, items_sent, book.status_count[ST_OK],
                 book.status_count[ST_INVALID], book.status_count[ST_EMPTY],
                 book.status_count[ST_FULL]);
        $display("Receiver held off for %0d cycles in %0d long stretches; %0d mismatches.",
                 hold_cycles, holds_done, book.errors);
        if (book.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
